// File: src/vtse_pkg.sv
// Shared types and constants for the VLAN tag stack editor.
package vtse_pkg;

    // Default stack depth
    localparam int MAX_TAGS_DEF = 8;

    // Fixed field widths
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 4;
    localparam int VID_W   = 13;
    localparam int COS_W   = 4;
    localparam int TAG_W   = 32;

    // Tag layout: {TPID, CoS[2:0], CFI, VLAN[11:0]}
    localparam logic [15:0]        TPID      = 16'h8100;
    localparam int                 CFI_POS   = 12;
    localparam logic [VID_W-1:0]   VLAN_MAX  = 13'd4095;
    localparam logic [COS_W-1:0]   COS_MAX   = 4'd7;

    typedef logic [TAG_W-1:0] t_tag;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_SET_CFI = 2'd2,
        REQ_CLR_CFI = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [INDEX_W-1:0] tag_index;
        logic               update_count;
        logic [VID_W-1:0]   vlan_id;
        logic [COS_W-1:0]   cos;
    } t_request;

    typedef struct packed {
        logic               error;
        logic [COUNT_W-1:0] tag_count;
        t_tag               tag_word;
    } t_result;

endpackage

// File: src/vtse_edit.sv
// Combinational edit of the tag stack for one request.
module vtse_edit import vtse_pkg::*; #(
    parameter int MAX_TAGS = MAX_TAGS_DEF
) (
    input  t_request           i_req,
    input  t_tag               i_store [MAX_TAGS],
    input  logic [COUNT_W-1:0] i_count,
    output t_tag               o_store [MAX_TAGS],
    output logic [COUNT_W-1:0] o_count,
    output t_result            o_result
);

    t_tag               ext [MAX_TAGS+1];
    t_tag               new_tag;
    logic               slot_ok;
    logic               field_ok;
    logic               pos_ok;
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] idx_m1;
    t_tag               sel_idx;
    t_tag               sel_m1;
    t_tag               cfi_tag;

    always_comb begin
        idx      = i_req.tag_index;
        idx_m1   = idx - INDEX_W'(1);
        new_tag  = {TPID, i_req.cos[2:0], 1'b0, i_req.vlan_id[11:0]};
        slot_ok  = idx < INDEX_W'(MAX_TAGS);
        field_ok = (i_req.vlan_id <= VLAN_MAX) && (i_req.cos <= COS_MAX);
        // 1-based position inside the counted stack
        pos_ok   = (idx != '0) && (idx <= i_count);

        // Extend the stack by one empty slot so that shifting down stays in range
        for (int s = 0; s < MAX_TAGS; s++) begin
            ext[s] = i_store[s];
        end
        ext[MAX_TAGS] = '0;

        // Pick the words at the addressed slot and the one below it
        sel_idx = '0;
        sel_m1  = '0;
        for (int s = 0; s < MAX_TAGS; s++) begin
            if (INDEX_W'(s) == idx) begin
                sel_idx = i_store[s];
            end
            if (INDEX_W'(s) == idx_m1) begin
                sel_m1 = i_store[s];
            end
        end
        cfi_tag = sel_m1;
        cfi_tag[CFI_POS] = (i_req.req_type == REQ_SET_CFI);

        // Hold by default
        for (int s = 0; s < MAX_TAGS; s++) begin
            o_store[s] = i_store[s];
        end
        o_count  = i_count;
        o_result = '{error: 1'b0, tag_count: '0, tag_word: '0};

        unique case (i_req.req_type)
            REQ_WRITE: begin
                if (!slot_ok) begin
                    o_result.error = 1'b1;
                end else if (!field_ok) begin
                    o_result.error    = 1'b1;
                    o_result.tag_word = sel_idx;
                end else begin
                    for (int s = 0; s < MAX_TAGS; s++) begin
                        if (INDEX_W'(s) == idx) begin
                            o_store[s] = new_tag;
                        end
                    end
                    if (i_req.update_count) begin
                        o_count = COUNT_W'(idx) + COUNT_W'(1);
                    end
                    o_result.tag_word = new_tag;
                end
            end
            REQ_REMOVE: begin
                if (idx == '0) begin
                    o_count = '0;
                end else if (idx > i_count) begin
                    o_result.error = 1'b1;
                end else begin
                    // Shift the later tags down by one; the top slot keeps its word
                    for (int s = 0; s < MAX_TAGS; s++) begin
                        if ((INDEX_W'(s + 1) >= idx) && (COUNT_W'(s + 1) < i_count)) begin
                            o_store[s] = ext[s+1];
                        end
                    end
                    o_count = i_count - COUNT_W'(1);
                    if (idx < i_count) begin
                        o_result.tag_word = sel_idx;
                    end
                end
            end
            REQ_SET_CFI, REQ_CLR_CFI: begin
                if (!pos_ok) begin
                    o_result.error = 1'b1;
                end else begin
                    for (int s = 0; s < MAX_TAGS; s++) begin
                        if (INDEX_W'(s) == idx_m1) begin
                            o_store[s] = cfi_tag;
                        end
                    end
                    o_result.tag_word = cfi_tag;
                end
            end
            default: begin
                o_result.error = 1'b1;
            end
        endcase

        o_result.tag_count = o_count;
    end

endmodule

// File: src/vlan_tag_stack_editor_top.sv
// Top level of the VLAN tag stack editor: input register, stack state, result register.
// A word is held in the input register while its stack edit is made, then its result in the result register.
// Throughput: one word per cycle while i_out_stall is low; the stack edit is combinational.
// Each word sees the stack as left by the word before it.
// Reset (synchronous, active low) empties both registers, clears every tag and the count.
module vlan_tag_stack_editor_top import vtse_pkg::*; #(
    parameter int MAX_TAGS = MAX_TAGS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [INDEX_W-1:0] i_tag_index,
    input  logic               i_update_count,
    input  logic [VID_W-1:0]   i_vlan_id,
    input  logic [COS_W-1:0]   i_cos,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_error,
    output logic [COUNT_W-1:0] o_tag_count,
    output logic [TAG_W-1:0]   o_tag_word
);

    logic               r_in_valid;
    t_request           r_req;
    t_tag               r_store [MAX_TAGS];
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_result            r_result;

    t_tag               n_store [MAX_TAGS];
    logic [COUNT_W-1:0] n_count;
    t_result            n_result;

    logic               out_free;
    logic               fire;
    logic               in_free;

    // Advance when the result register is empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign in_free    = !r_in_valid || fire;
    assign o_in_stall = !in_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
        if (in_free && i_in_valid) begin
            r_req <= '{req_type:     t_req_type'(i_req_type),
                       tag_index:    i_tag_index,
                       update_count: i_update_count,
                       vlan_id:      i_vlan_id,
                       cos:          i_cos};
        end
    end

    // Edit the stack for the held word
    vtse_edit #(
        .MAX_TAGS (MAX_TAGS)
    ) u_edit (
        .i_req    (r_req),
        .i_store  (r_store),
        .i_count  (r_count),
        .o_store  (n_store),
        .o_count  (n_count),
        .o_result (n_result)
    );

    // Stack state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_TAGS; s++) begin
                r_store[s] <= '0;
            end
            r_count <= '0;
        end else if (fire) begin
            r_store <= n_store;
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_error     = r_result.error;
    assign o_tag_count = r_result.tag_count;
    assign o_tag_word  = r_result.tag_word;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the VLAN tag stack editor with its own stack predictor.
`timescale 1ns / 100ps

module tb;
    import vtse_pkg::*;

    localparam int MAX_TAGS = MAX_TAGS_DEF;
    localparam int N_RANDOM = 650;
    localparam int MAX_SHOWN = 10;

    // Clock, reset and block ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type = '0;
    logic [INDEX_W-1:0] i_tag_index = '0;
    logic               i_update_count = 1'b0;
    logic [VID_W-1:0]   i_vlan_id = '0;
    logic [COS_W-1:0]   i_cos = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_error;
    logic [COUNT_W-1:0] o_tag_count;
    logic [TAG_W-1:0]   o_tag_word;

    // Request words waiting to be sent, and stack reports still owed by the block
    t_request tag_requests[$];
    t_result  stack_reports[$];

    // Shadow of the tag stack
    t_tag stack_tags[MAX_TAGS];
    int   stack_depth;

    int   mismatches = 0;
    int   words_in = 0;
    logic in_fire = 1'b0;

    // Sender and receiver pacing
    int   in_gap = 0;
    logic calm_in = 1'b0;
    int   out_left = 0;
    logic out_rnd = 1'b0;
    logic calm_out = 1'b0;
    logic long_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    vlan_tag_stack_editor_top #(.MAX_TAGS(MAX_TAGS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_tag_index    (i_tag_index),
        .i_update_count (i_update_count),
        .i_vlan_id      (i_vlan_id),
        .i_cos          (i_cos),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_error        (o_error),
        .o_tag_count    (o_tag_count),
        .o_tag_word     (o_tag_word)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one request to the shadow stack and return the report it gives
    function automatic t_result edit_tag_stack(t_request rq);
        t_result res;
        int      idx;
        int      j;
        res = '0;
        idx = rq.tag_index;
        case (rq.req_type)
            REQ_WRITE: begin
                if (idx >= MAX_TAGS) begin
                    res.error = 1'b1;
                end else if (rq.vlan_id > VLAN_MAX || rq.cos > COS_MAX) begin
                    res.error = 1'b1;
                    res.tag_word = stack_tags[idx];
                end else begin
                    // fresh tag always goes in with CFI clear
                    stack_tags[idx] = {TPID, rq.cos[2:0], 1'b0, rq.vlan_id[11:0]};
                    if (rq.update_count)
                        stack_depth = idx + 1;
                    res.tag_word = stack_tags[idx];
                end
            end
            REQ_REMOVE: begin
                if (idx == 0) begin
                    // empty the stack, stored words stay behind
                    stack_depth = 0;
                end else if (idx > stack_depth) begin
                    res.error = 1'b1;
                end else begin
                    // shift the later tags down, top slot keeps its old word
                    for (j = idx; j < stack_depth && j < MAX_TAGS; j++)
                        stack_tags[j-1] = stack_tags[j];
                    stack_depth = stack_depth - 1;
                    if (idx <= stack_depth)
                        res.tag_word = stack_tags[idx-1];
                end
            end
            default: begin
                if (idx == 0 || idx > stack_depth || idx - 1 >= MAX_TAGS) begin
                    res.error = 1'b1;
                end else begin
                    stack_tags[idx-1][CFI_POS] = (rq.req_type == REQ_SET_CFI);
                    res.tag_word = stack_tags[idx-1];
                end
            end
        endcase
        res.tag_count = stack_depth[COUNT_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_request make_req(t_req_type kind, int idx, bit upd, int vid, int cos);
        t_request rq;
        rq.req_type     = kind;
        rq.tag_index    = idx[INDEX_W-1:0];
        rq.update_count = upd;
        rq.vlan_id      = vid[VID_W-1:0];
        rq.cos          = cos[COS_W-1:0];
        return rq;
    endfunction

    // Random request, mostly well formed, with some out-of-range fields
    function automatic t_request random_req();
        t_request rq;
        int       r;
        int       idx;
        int       vid;
        int       cos;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
            vid = ($urandom_range(0, 9) == 0) ? $urandom_range(4096, 8191)
                                              : $urandom_range(0, 4095);
            cos = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
            rq = make_req(REQ_WRITE, idx, $urandom_range(0, 1), vid, cos);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 85)
                idx = $urandom_range(1, 8);
            else if (r < 88)
                idx = 0;
            else
                idx = $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            // other fields carry noise, the block must ignore them
            rq = make_req(r < 35 ? REQ_REMOVE : (r < 70 ? REQ_SET_CFI : REQ_CLR_CFI),
                          idx, $urandom_range(0, 1), $urandom_range(0, 8191),
                          $urandom_range(0, 15));
        end
        return rq;
    endfunction

    // Send words from the queue, hold a stalled word steady
    always @(negedge i_clk) begin
        t_request nxt;
        logic     give;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            give = 1'b0;
            if (in_gap > 0 && !long_hold) begin
                in_gap <= in_gap - 1;
            end else if (tag_requests.size() > 0) begin
                nxt = tag_requests.pop_front();
                give = 1'b1;
                i_req_type     <= nxt.req_type;
                i_tag_index    <= nxt.tag_index;
                i_update_count <= nxt.update_count;
                i_vlan_id      <= nxt.vlan_id;
                i_cos          <= nxt.cos;
                if ($urandom_range(0, 39) == 0)
                    calm_in = ~calm_in;
                in_gap <= calm_in ? 0 : pick_gap();
            end
            i_in_valid <= give;
        end
    end

    // Receiver stall: random runs, calm stretches, and the long hold-off
    always @(negedge i_clk) begin
        if (out_left > 0) begin
            out_left = out_left - 1;
        end else begin
            if ($urandom_range(0, 29) == 0)
                calm_out = ~calm_out;
            out_rnd = calm_out ? 1'b0 : ($urandom_range(0, 2) == 0);
            out_left = pick_gap();
        end
        i_out_stall <= long_hold || out_rnd;
    end

    // Hold off the receiver once for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (!hold_done && !long_hold && words_in >= 150) begin
            long_hold <= 1'b1;
            hold_left <= 100;
        end else if (long_hold) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) begin
                long_hold <= 1'b0;
                hold_done <= 1'b1;
            end
        end
    end

    // Check each accepted report against the oldest prediction, then predict new words
    always @(posedge i_clk) begin
        t_result want;
        t_request got_req;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (stack_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected word err=%0b count=%0d tag=%08h",
                                 $realtime, o_error, o_tag_count, o_tag_word);
                end else begin
                    want = stack_reports.pop_front();
                    if (o_error !== want.error || o_tag_count !== want.tag_count ||
                        o_tag_word !== want.tag_word) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: mismatch exp err=%0b count=%0d tag=%08h, got err=%0b count=%0d tag=%08h",
                                     $realtime, want.error, want.tag_count, want.tag_word,
                                     o_error, o_tag_count, o_tag_word);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                got_req.req_type     = t_req_type'(i_req_type);
                got_req.tag_index    = i_tag_index;
                got_req.update_count = i_update_count;
                got_req.vlan_id      = i_vlan_id;
                got_req.cos          = i_cos;
                stack_reports.push_back(edit_tag_stack(got_req));
                words_in++;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int k;
        for (k = 0; k < MAX_TAGS; k++)
            stack_tags[k] = '0;
        stack_depth = 0;

        // directed: extremes of every field, every request type, the corner cases
        tag_requests.push_back(make_req(REQ_WRITE, 0, 1, 0, 0));
        tag_requests.push_back(make_req(REQ_WRITE, 1, 1, 4095, 7));
        tag_requests.push_back(make_req(REQ_WRITE, 2, 1, 4096, 0));
        tag_requests.push_back(make_req(REQ_WRITE, 1, 0, 8191, 15));
        tag_requests.push_back(make_req(REQ_WRITE, 1, 1, 100, 8));
        tag_requests.push_back(make_req(REQ_WRITE, 8, 1, 5, 1));
        tag_requests.push_back(make_req(REQ_WRITE, 15, 0, 5, 1));
        tag_requests.push_back(make_req(REQ_WRITE, 7, 0, 'hABC, 5));
        tag_requests.push_back(make_req(REQ_WRITE, 7, 1, 'h555, 3));
        tag_requests.push_back(make_req(REQ_SET_CFI, 1, 1, 8191, 15));
        tag_requests.push_back(make_req(REQ_SET_CFI, 8, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_CLR_CFI, 1, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_SET_CFI, 0, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_CLR_CFI, 9, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_SET_CFI, 15, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_REMOVE, 1, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_REMOVE, 7, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_REMOVE, 3, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_REMOVE, 15, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_REMOVE, 0, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_REMOVE, 1, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_CLR_CFI, 1, 0, 0, 0));
        tag_requests.push_back(make_req(REQ_WRITE, 0, 0, 1234, 6));
        tag_requests.push_back(make_req(REQ_WRITE, 2, 1, 2048, 4));
        for (k = 0; k < N_RANDOM; k++)
            tag_requests.push_back(random_req());

        // hold reset, then release it
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all words sent, every report back, then let the pipe settle
        while (tag_requests.size() > 0 || i_in_valid || stack_reports.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        mismatches += stack_reports.size();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
